>>> sv/hmf_pkg.sv
package hmf_pkg;

    // default sizes
    localparam int VALUE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF = 8;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input transaction
        logic rd;     // read the bin of the captured value
        logic upd;    // write back the incremented count, update the leader record
        logic emit;   // load the result register, restart the leader record
        logic clr;    // clear one bin of the sweep
    } hmf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_item;  // captured value closes its set
        logic clr_last;   // sweep is at its final bin
        logic out_full;   // result register still holds an untaken result
    } hmf_sts_t;

endpackage

>>> sv/hmf_datapath.sv
module hmf_datapath
    import hmf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hmf_cmd_t              cmd,
    output hmf_sts_t              sts,
    input  logic [VALUE_BITS-1:0] s_sample_value,
    input  logic                  s_last_of_set,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_mode_value,
    output logic                  m_mode_tied
);

    localparam int BIN_COUNT = 1 << VALUE_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [VALUE_BITS-1:0] PTR_LAST  = '1;

    // histogram memory, one count per value
    logic [COUNT_BITS-1:0] bin_mem [BIN_COUNT];

    logic [VALUE_BITS-1:0] sample_reg;
    logic                  last_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [VALUE_BITS-1:0] clr_ptr_reg;
    logic [VALUE_BITS-1:0] clr_ptr_next;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic [COUNT_BITS-1:0] best_count_next;
    logic [VALUE_BITS-1:0] best_value_reg;
    logic [VALUE_BITS-1:0] best_value_next;
    logic                  tie_reg;
    logic                  tie_next;
    logic [VALUE_BITS-1:0] mode_value_reg;
    logic                  mode_tied_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;

    logic [COUNT_BITS-1:0] count_inc;
    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_sample_value;
            last_reg   <= s_last_of_set;
        end
    end

    // saturating increment of the fetched count
    assign count_inc = (rd_data_reg == COUNT_MAX) ? rd_data_reg
                                                  : rd_data_reg + COUNT_BITS'(1);

    // single write port shared by the update and the clearing sweep
    assign wr_en   = cmd.upd | cmd.clr;
    assign wr_addr = cmd.clr ? clr_ptr_reg : sample_reg;
    assign wr_data = cmd.clr ? '0 : count_inc;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bin_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= bin_mem[sample_reg];
        end
    end

    // sweep pointer, wraps to zero at the end of a pass
    assign clr_ptr_next = cmd.clr ? clr_ptr_reg + VALUE_BITS'(1) : clr_ptr_reg;

    // leader record: highest count, its value, tie flag
    always_comb begin
        best_count_next = best_count_reg;
        best_value_next = best_value_reg;
        tie_next        = tie_reg;
        if (cmd.emit) begin
            best_count_next = '0;
            best_value_next = '0;
            tie_next        = 1'b0;
        end else if (cmd.upd) begin
            if (count_inc > best_count_reg) begin
                best_count_next = count_inc;
                best_value_next = sample_reg;
                tie_next        = 1'b0;
            end else if (count_inc == best_count_reg && sample_reg != best_value_reg) begin
                tie_next = 1'b1;
            end
        end
    end

    // result register valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg    <= '0;
            best_count_reg <= '0;
            best_value_reg <= '0;
            tie_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            clr_ptr_reg    <= clr_ptr_next;
            best_count_reg <= best_count_next;
            best_value_reg <= best_value_next;
            tie_reg        <= tie_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload, value forced to zero on a tie
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            mode_value_reg <= tie_reg ? '0 : best_value_reg;
            mode_tied_reg  <= tie_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mode_value = mode_value_reg;
    assign m_mode_tied  = mode_tied_reg;

    assign sts.last_item = last_reg;
    assign sts.clr_last  = (clr_ptr_reg == PTR_LAST);
    assign sts.out_full  = m_valid_reg;

    // a tied result never carries a value
    a_tie_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode_tied |-> m_mode_value == '0)
        else $error("tied result with non-zero value");

    // a new result always leaves a fresh leader record behind
    a_emit_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> best_count_reg == '0 && !tie_reg)
        else $error("leader record not restarted after result");

    // the sweep never competes with a count update for the write port
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr |-> !cmd.upd && !cmd.rd)
        else $error("sweep overlaps a histogram access");

    // a result is only loaded into an empty register
    a_emit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !m_valid_reg)
        else $error("result register overwritten");

endmodule

>>> sv/hmf_ctrl.sv
module hmf_ctrl
    import hmf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output hmf_cmd_t cmd,
    input  hmf_sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   s_ready_next;
    logic   accept;

    assign accept = s_valid && s_ready_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = sts.last_item ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!sts.out_full) begin
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign s_ready_next = (state_next == ST_IDLE);

    // state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    // commands
    assign cmd.load = accept;
    assign cmd.rd   = (state_reg == ST_READ);
    assign cmd.upd  = (state_reg == ST_UPDATE);
    assign cmd.emit = (state_reg == ST_EMIT) && !sts.out_full;
    assign cmd.clr  = (state_reg == ST_CLEAR);

    assign s_ready = s_ready_reg;

    // ready only ever offered while waiting for a transaction
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> state_reg == ST_IDLE)
        else $error("ready outside idle");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready_reg && state_reg == ST_READ)
        else $error("transaction not followed by a read");

endmodule

>>> sv/histogram_mode_finder_core.sv
// a closing value's result shows on m_valid after its read, write back and emit states
// each value passes idle, read and write back over the single-port bin memory; no new value is taken before that
// after each result, and after reset, a sweep zeroes all 2^VALUE_BITS bins of the bin memory;
// s_ready stays low during the sweep and while a finished result waits for the previous one
// reset: aresetn synchronous active low; clears control, leader record and result valid,
// then starts the clearing sweep
module histogram_mode_finder_core
    import hmf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_sample_value,
    input  logic                  s_last_of_set,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_mode_value,
    output logic                  m_mode_tied
);

    hmf_cmd_t cmd;
    hmf_sts_t sts;

    // sequencer
    hmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // histogram, leader record and result register
    hmf_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_sample_value (s_sample_value),
        .s_last_of_set  (s_last_of_set),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode_value   (m_mode_value),
        .m_mode_tied    (m_mode_tied)
    );

endmodule
